// File: rtl/core/integer_to_radix_text_assert.svh
// Assertion macros shared by the radix text converter.
`ifndef INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`define INTEGER_TO_RADIX_TEXT_ASSERT_SVH

// Checked only while out of reset.
`define ITRT_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ITRT_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/itrt_pkg.sv
package itrt_pkg;

  localparam int VALUE_W     = 32;
  localparam int MAX_DIGITS  = 32;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W       = $clog2(MAX_DIGITS);

  // The divider retires this many quotient bits per cycle.
  localparam int DIV_BITS    = 8;
  localparam int DIV_CHUNKS  = VALUE_W / DIV_BITS;
  localparam int DIV_CNT_W   = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);
  localparam logic [DIGIT_W-1:0] DIGIT_TOP  = DIGIT_W'(35);

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  // Micro-operations, one per control word.
  typedef enum logic [5:0] {
    OP_WAIT  = 6'b000001,
    OP_DIV   = 6'b000010,
    OP_STORE = 6'b000100,
    OP_SIGN  = 6'b001000,
    OP_EMIT  = 6'b010000,
    OP_INV   = 6'b100000
  } op_t;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT  = 3'd0;
  localparam step_t STEP_DIV   = 3'd1;
  localparam step_t STEP_STORE = 3'd2;
  localparam step_t STEP_SIGN  = 3'd3;
  localparam step_t STEP_EMIT  = 3'd4;
  localparam step_t STEP_INV   = 3'd5;

  typedef struct packed {
    op_t   op;
    step_t jump;
  } ucode_t;

  typedef struct packed {
    logic load;
    logic step;
    logic clr_rem;
  } div_ctrl_t;

  // Control store. The jump target is taken when the step's condition holds.
  function automatic ucode_t ucode(input step_t step);
    ucode_t w;
    case (step)
      STEP_WAIT:  w = '{op: OP_WAIT,  jump: STEP_INV};
      STEP_DIV:   w = '{op: OP_DIV,   jump: STEP_DIV};
      STEP_STORE: w = '{op: OP_STORE, jump: STEP_DIV};
      STEP_SIGN:  w = '{op: OP_SIGN,  jump: STEP_EMIT};
      STEP_EMIT:  w = '{op: OP_EMIT,  jump: STEP_WAIT};
      STEP_INV:   w = '{op: OP_INV,   jump: STEP_WAIT};
      default:    w = '{op: OP_WAIT,  jump: STEP_WAIT};
    endcase
    return w;
  endfunction

  function automatic char_t digit_char(input digit_t d);
    char_t c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else if (d <= DIGIT_TOP) begin
      c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
    end else begin
      c = CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/itrt_if.sv
interface itrt_in_if import itrt_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itrt_out_if import itrt_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t char_code;
  logic  last;
  logic  radix_invalid;

  modport source (output valid, output char_code, output last, output radix_invalid,
                  input ready);
  modport sink   (input valid, input char_code, input last, input radix_invalid,
                  output ready);
endinterface

// File: rtl/core/itrt_divider.sv
module itrt_divider import itrt_pkg::*; (
  input  logic      clk,
  input  div_ctrl_t ctrl,
  input  value_t    load_val,
  input  radix_t    radix,
  output value_t    quot,
  output digit_t    rem
);

  value_t q_r, q_nxt;
  digit_t rem_r, rem_nxt;

  // Restoring division, one chunk of dividend bits per stepped cycle. The
  // partial remainder stays below the radix, so each bit step is a 7-bit compare.
  always_comb begin
    logic [DIGIT_W:0]    t;
    logic [DIV_BITS-1:0] qbits;
    digit_t              r;
    r     = rem_r;
    qbits = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, q_r[VALUE_W-1-i]};
      if (t >= {1'b0, radix}) begin
        r = DIGIT_W'(t - {1'b0, radix});
        qbits[DIV_BITS-1-i] = 1'b1;
      end else begin
        r = t[DIGIT_W-1:0];
      end
    end

    q_nxt   = q_r;
    rem_nxt = rem_r;
    if (ctrl.load) begin
      q_nxt   = load_val;
      rem_nxt = '0;
    end else if (ctrl.step) begin
      q_nxt   = {q_r[VALUE_W-DIV_BITS-1:0], qbits};
      rem_nxt = r;
    end else if (ctrl.clr_rem) begin
      rem_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign quot = q_r;
  assign rem  = rem_r;

endmodule

// File: rtl/core/integer_to_radix_text.sv
// Signed integer to ASCII text converter.
// in_ch carries one two's complement value per item; out_ch returns its text
// one character per item, most significant first, with '-' leading for a
// negative value and last set on the final character. The radix comes from
// cfg_wdata, written when cfg_we is high; change it only while idle.
// A radix outside 2..36 yields one item with char_code 0, last and
// radix_invalid set, loaded by the invalid step once the output slot is free.
// A small control store sequences the work. Each digit is worked out in the
// shared divider, eight quotient bits a cycle, and then written by the store step.
// After the last digit the sign step and then the emit step send the text,
// one character per cycle while out_ch is ready.
// The next value is taken as soon as the last character sits in the output
// register. If out_ch stalls, the sequence holds at its sign, emit or invalid
// step with the pending character kept in the output register.
// After reset the radix is 10 and the block waits for its first item; the
// digit store needs no clearing since each digit is written before use.
module integer_to_radix_text import itrt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  itrt_in_if.sink           in_ch,
  itrt_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [RADIX_W-1:0] cfg_wdata
);

  radix_t                radix_r;
  step_t                 step_r, step_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  neg_r, neg_nxt;

  logic                  out_valid_r;
  char_t                 out_char_r;
  logic                  out_last_r;
  logic                  out_inv_r;

  logic                  out_load;
  char_t                 out_char_nxt;
  logic                  out_last_nxt;
  logic                  out_inv_nxt;

  digit_t                store [MAX_DIGITS];
  digit_t                rd_data_r;
  logic                  store_we;

  ucode_t                uw;
  div_ctrl_t             dctl;
  value_t                mag;
  value_t                quot;
  digit_t                rem;
  logic                  radix_ok;
  logic                  slot_free;
  logic                  accept;

  assign uw        = ucode(step_r);
  assign radix_ok  = (radix_r >= RADIX_MIN) && (radix_r <= RADIX_MAX);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (uw.op == OP_WAIT);
  assign accept    = in_ch.valid && in_ch.ready;
  assign mag       = in_ch.value[VALUE_W-1] ? (VALUE_W'(0) - in_ch.value) : in_ch.value;

  itrt_divider u_div (
    .clk      (clk),
    .ctrl     (dctl),
    .load_val (mag),
    .radix    (radix_r),
    .quot     (quot),
    .rem      (rem)
  );

  always_comb begin
    step_nxt     = step_r;
    div_cnt_nxt  = div_cnt_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    neg_nxt      = neg_r;
    dctl         = '0;
    store_we     = 1'b0;
    out_load     = 1'b0;
    out_char_nxt = CHAR_NUL;
    out_last_nxt = 1'b0;
    out_inv_nxt  = 1'b0;

    case (uw.op)
      OP_WAIT: begin
        if (accept) begin
          dctl.load   = 1'b1;
          div_cnt_nxt = '0;
          count_nxt   = '0;
          if (radix_ok) begin
            neg_nxt  = in_ch.value[VALUE_W-1];
            step_nxt = step_r + STEP_W'(1);
          end else begin
            neg_nxt  = 1'b0;
            step_nxt = uw.jump;
          end
        end
      end
      OP_DIV: begin
        dctl.step = 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_CHUNKS - 1)) begin
          div_cnt_nxt = '0;
          step_nxt    = step_r + STEP_W'(1);
        end else begin
          div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        end
      end
      OP_STORE: begin
        store_we     = 1'b1;
        dctl.clr_rem = 1'b1;
        count_nxt    = count_r + CNT_W'(1);
        if ((quot != '0) && (count_nxt < CNT_W'(MAX_DIGITS))) begin
          step_nxt = uw.jump;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      OP_SIGN: begin
        // Point the store read at the most significant digit.
        idx_nxt = IDX_W'(count_r - CNT_W'(1));
        if (!neg_r) begin
          step_nxt = step_r + STEP_W'(1);
        end else if (slot_free) begin
          out_load     = 1'b1;
          out_char_nxt = CHAR_MINUS;
          step_nxt     = step_r + STEP_W'(1);
        end
      end
      OP_EMIT: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_char_nxt = digit_char(rd_data_r);
          out_last_nxt = (idx_r == '0);
          if (idx_r == '0) begin
            step_nxt = uw.jump;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      OP_INV: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_char_nxt = CHAR_NUL;
          out_last_nxt = 1'b1;
          out_inv_nxt  = 1'b1;
          step_nxt     = uw.jump;
        end
      end
      default: begin
        step_nxt = STEP_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= RADIX_RESET;
      step_r      <= STEP_WAIT;
      div_cnt_r   <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
      step_r    <= step_nxt;
      div_cnt_r <= div_cnt_nxt;
      count_r   <= count_nxt;
      idx_r     <= idx_nxt;
      neg_r     <= neg_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
      out_inv_r  <= out_inv_nxt;
    end
  end

  // Digit store: written while dividing, read back in reverse order.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[count_r[IDX_W-1:0]] <= rem;
    end
    rd_data_r <= store[idx_nxt];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.char_code     = out_char_r;
  assign out_ch.last          = out_last_r;
  assign out_ch.radix_invalid = out_inv_r;

`include "integer_to_radix_text_assert.svh"

  `ITRT_CHECK(a_inv_single, (out_ch.valid && out_ch.radix_invalid) |-> (out_ch.last && (out_ch.char_code == CHAR_NUL)), "invalid radix result must be a lone empty item")
  `ITRT_CHECK(a_count_bound, count_r <= CNT_W'(MAX_DIGITS), "digit count beyond store depth")
  `ITRT_CHECK(a_bad_radix_path, (accept && !radix_ok) |=> (step_r == STEP_INV), "bad radix did not reach the invalid step")
  `ITRT_CHECK(a_no_emit_in_div, ((uw.op == OP_DIV) || (uw.op == OP_STORE)) |-> !out_load, "output loaded while dividing")
  `ITRT_CHECK_ALWAYS(a_reset_idle, !rst_n |=> ((step_r == STEP_WAIT) && !out_valid_r), "reset did not return to idle")

endmodule

// File: tb/integer_to_radix_text_tb.sv
module integer_to_radix_text_tb;
  import itrt_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    char_t char_code;
    logic  last;
    logic  radix_invalid;
  } text_char_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  radix_t cfg_wdata;

  itrt_in_if  in_ch ();
  itrt_out_if out_ch ();

  integer_to_radix_text dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  value_t     pending_values[$];
  value_t     taken_values[$];
  text_char_t text_q[$];
  radix_t     radix_shadow;
  logic       idle_on;
  int         failures = 0;
  int         quiet_cycles;
  int         send_gap;
  int         take_gap;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Expected text of one value in the current radix, most significant first.
  function automatic void predict_text(input value_t v);
    value_t mag;
    digit_t digits[$];
    logic   neg;
    digit_t d;
    if (radix_shadow < RADIX_MIN || radix_shadow > RADIX_MAX) begin
      text_q.push_back('{CHAR_NUL, 1'b1, 1'b1});
      return;
    end
    neg = v[VALUE_W-1];
    mag = neg ? -v : v;
    do begin
      digits.push_front(digit_t'(mag % radix_shadow));
      mag = mag / radix_shadow;
    end while (mag != '0 && digits.size() < MAX_DIGITS);
    if (neg) begin
      text_q.push_back('{CHAR_MINUS, 1'b0, 1'b0});
    end
    for (int i = 0; i < digits.size(); i++) begin
      d = digits[i];
      text_q.push_back('{(d < DIGIT_TEN) ? CHAR_ZERO + char_t'(d) : CHAR_A + char_t'(d - DIGIT_TEN),
                         i == digits.size() - 1, 1'b0});
    end
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  function automatic void send(input value_t v);
    pending_values.push_back(v);
  endfunction

  function automatic value_t pick_value(input radix_t r);
    value_t v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = value_t'($urandom_range(0, 2 * r + 2));
      2: v = -value_t'($urandom_range(1, 2 * r + 2));
      3: v = $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                  : 32'h8000_0000 + $urandom_range(0, 3);
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  // Feeds the input channel from the pending list; an offered item is held until taken.
  always @(posedge clk) begin : feed_proc
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken_values.push_back(in_ch.value);
        void'(pending_values.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        in_ch.valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (idle_on && pending_values.size() != 0 && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 18) - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_values.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.value <= pending_values[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Expectations are formed on the falling edge after the item is taken, so that the
  // result checker never races with them.
  always @(negedge clk) begin
    while (taken_values.size() != 0) begin
      predict_text(taken_values.pop_front());
    end
  end

  always @(posedge clk) begin : text_check_proc
    text_char_t got;
    text_char_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.char_code, out_ch.last, out_ch.radix_invalid};
        if (text_q.size() == 0) begin
          note_failure($sformatf("unexpected character %h last %b invalid %b",
                                 got.char_code, got.last, got.radix_invalid));
        end else begin
          want = text_q.pop_front();
          if (got.char_code !== want.char_code || got.last !== want.last ||
              got.radix_invalid !== want.radix_invalid) begin
            note_failure($sformatf("expected %h/%b/%b, got %h/%b/%b",
                                   want.char_code, want.last, want.radix_invalid,
                                   got.char_code, got.last, got.radix_invalid));
          end
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        take_gap = $urandom_range(1, 18) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic set_radix(input radix_t r);
    @(posedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= r;
    radix_shadow = r;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Holds back further items until every expected character has arrived.
  task automatic drain();
    while (pending_values.size() != 0 || taken_values.size() != 0 || text_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus_proc
    radix_t r;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    idle_on       = 1'b1;
    radix_shadow  = RADIX_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Decimal straight out of reset, including both ends of the range.
    send('0);
    send(value_t'(1));
    send(value_t'(-1));
    send(value_t'(9));
    send(value_t'(10));
    send(value_t'(-10));
    send(32'h7fff_ffff);
    send(32'h8000_0000);
    drain();

    set_radix(RADIX_MIN);
    send('0);
    send(value_t'(1));
    send(value_t'(-1));
    send(32'h8000_0000);
    send(32'h7fff_ffff);
    drain();

    set_radix(RADIX_MAX);
    send(value_t'(35));
    send(value_t'(36));
    send(value_t'(-35));
    send(32'h8000_0000);
    send(32'h7fff_ffff);
    drain();

    set_radix(radix_t'(16));
    send(32'hdead_beef);
    drain();

    // Rejected bases each give a single flagged item.
    set_radix(radix_t'(0));
    send(value_t'(5));
    drain();
    set_radix(radix_t'(1));
    send(value_t'(-7));
    drain();
    set_radix(radix_t'(37));
    send('0);
    drain();
    set_radix(radix_t'(63));
    send(32'h8000_0000);
    drain();

    for (int p = 0; p < 7; p++) begin
      if (p == 3) begin
        r = $urandom_range(0, 1) ? radix_t'($urandom_range(0, 1))
                                 : radix_t'($urandom_range(37, 63));
      end else begin
        r = radix_t'($urandom_range(2, 36));
      end
      idle_on = (p != 4 && p != 6);
      set_radix(r);
      for (int i = 0; i < 12; i++) begin
        send(pick_value(r));
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (failures == 0 && text_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: integer_to_radix_text.f
+incdir+rtl/core
rtl/core/itrt_pkg.sv
rtl/core/itrt_if.sv
rtl/core/itrt_divider.sv
rtl/core/integer_to_radix_text.sv
tb/integer_to_radix_text_tb.sv
